@@ src/idll_pkg.sv @@
// Shared types and constants for the indexed doubly linked list core.
`default_nettype none
package idll_pkg;

  localparam int NUM_SLOTS = 15;
  localparam int SLOT_W    = 4;
  localparam int VALUE_W   = 64;
  localparam int COUNT_W   = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_ANCHOR = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef struct packed {
    logic   func;
    slot_t  anchor;
    value_t value;
  } req_t;

  typedef struct packed {
    status_t status;
    slot_t   slot;
    count_t  live_count;
  } rsp_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t    op;
    logic   in_range;
    slot_t  anchor;
    value_t value;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage
`default_nettype wire

@@ src/indexed_doubly_linked_list_core.sv @@
// Top level: indexed doubly linked list with free chain, front queue and back sequencer.
//
//   channel   ports                 beat taken when
//   request   start, busy, req      start && !busy at the clock edge
//   result    done, rsp             done high for one cycle; always taken
//
// An insert steps through CHECK, INS1, INS2 and INS3, a delete through CHECK, DEL1
// and DEL2, and an error ends in CHECK; the sequencer pops the next command in IDLE.
// The back sequencer reads and writes the link arrays one entry per array per cycle.
// The front queue holds two commands, so busy rises only when both are waiting.
// Synchronous reset restores the free chain and empties the list.
`default_nettype none
module indexed_doubly_linked_list_core
  import idll_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  q_head_t head;
  logic    pop;

  idll_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .head  (head),
    .pop   (pop)
  );

  idll_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .done (done),
    .rsp  (rsp)
  );

endmodule
`default_nettype wire

@@ src/idll_front.sv @@
// Front end: accepts request beats, classifies them and queues them for the back end.
`default_nettype none
module idll_front
  import idll_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire req_t    req,
  output q_head_t      head,
  input  wire logic    pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             do_pop;
  cmd_t             cls;

  assign busy   = (fill == CNT_W'(QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (fill != '0);

  always_comb begin
    cls.op       = req.func ? OP_DELETE : OP_INSERT;
    cls.in_range = ({1'b0, req.anchor} <= (SLOT_W+1)'(NUM_SLOTS));
    cls.anchor   = req.anchor;
    cls.value    = req.value;
  end

  assign head.valid = (fill != '0);
  assign head.cmd   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/idll_back.sv @@
// Back end: sequences list updates over the link arrays and drives the result beat.
`default_nettype none
module idll_back
  import idll_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_head_t head,
  output logic         pop,
  output logic         done,
  output rsp_t         rsp
);

  localparam int DEPTH = NUM_SLOTS + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INS1,
    S_INS2,
    S_INS3,
    S_DEL1,
    S_DEL2
  } state_t;

  state_t state;
  cmd_t   cur;
  slot_t  s_slot;
  slot_t  nfree;
  slot_t  n_link;
  slot_t  p_link;
  slot_t  free_head;
  count_t count;

  value_t value_store [DEPTH];
  slot_t  next_link   [DEPTH];
  slot_t  prev_link   [DEPTH];
  logic   in_use      [DEPTH];

  logic bad_ins_anchor;
  logic bad_del_anchor;
  logic full;

  assign pop = (state == S_IDLE) && head.valid;

  assign bad_ins_anchor = !cur.in_range || (cur.anchor != '0 && !in_use[cur.anchor]);
  assign bad_del_anchor = !cur.in_range || cur.anchor == '0 || !in_use[cur.anchor];
  assign full = ({1'b0, count} >= (COUNT_W+1)'(NUM_SLOTS)) || free_head == '0 ||
                ({1'b0, free_head} > (SLOT_W+1)'(NUM_SLOTS));

  // Value store: written only, no reset
  always_ff @(posedge clk) begin
    if (state == S_INS1) begin
      value_store[s_slot] <= cur.value;
    end else if (state == S_DEL1) begin
      value_store[cur.anchor] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      free_head <= slot_t'(1);
      count     <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        next_link[i] <= (i == 0 || i == NUM_SLOTS) ? '0 : slot_t'(i + 1);
        prev_link[i] <= '0;
        in_use[i]    <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur   <= head.cmd;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (cur.op == OP_INSERT) begin
            if (bad_ins_anchor) begin
              done  <= 1'b1;
              rsp   <= '{status: ST_NO_ANCHOR, slot: '0, live_count: count};
              state <= S_IDLE;
            end else if (full) begin
              done  <= 1'b1;
              rsp   <= '{status: ST_FULL, slot: '0, live_count: count};
              state <= S_IDLE;
            end else begin
              s_slot <= free_head;
              nfree  <= next_link[free_head];
              state  <= S_INS1;
            end
          end else begin
            if (count == '0) begin
              done  <= 1'b1;
              rsp   <= '{status: ST_EMPTY, slot: '0, live_count: count};
              state <= S_IDLE;
            end else if (bad_del_anchor) begin
              done  <= 1'b1;
              rsp   <= '{status: ST_NO_ANCHOR, slot: '0, live_count: count};
              state <= S_IDLE;
            end else begin
              p_link <= prev_link[cur.anchor];
              n_link <= next_link[cur.anchor];
              state  <= S_DEL1;
            end
          end
        end
        S_INS1: begin
          n_link <= next_link[cur.anchor];
          state  <= S_INS2;
        end
        S_INS2: begin
          next_link[s_slot] <= n_link;
          prev_link[s_slot] <= cur.anchor;
          free_head         <= nfree;
          state             <= S_INS3;
        end
        S_INS3: begin
          next_link[cur.anchor] <= s_slot;
          prev_link[n_link]     <= s_slot;
          in_use[s_slot]        <= 1'b1;
          count                 <= count + 1'b1;
          done                  <= 1'b1;
          rsp   <= '{status: ST_OK, slot: s_slot, live_count: count + 1'b1};
          state <= S_IDLE;
        end
        S_DEL1: begin
          next_link[p_link] <= n_link;
          prev_link[n_link] <= p_link;
          state             <= S_DEL2;
        end
        S_DEL2: begin
          in_use[cur.anchor]    <= 1'b0;
          prev_link[cur.anchor] <= '0;
          next_link[cur.anchor] <= free_head;
          free_head             <= cur.anchor;
          count                 <= count - 1'b1;
          done                  <= 1'b1;
          rsp   <= '{status: ST_OK, slot: cur.anchor, live_count: count - 1'b1};
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/idll_checker.sv @@
// Port-level checker for the list core and its bind.
`default_nettype none
module idll_checker
  import idll_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic done,
  input wire rsp_t rsp
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat right after reset");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two result beats in consecutive cycles");

  a_error_slot: assert property (@(posedge clk) disable iff (rst)
      done && rsp.status != ST_OK |-> rsp.slot == '0)
    else $error("error result carries a slot");

  a_ok_slot: assert property (@(posedge clk) disable iff (rst)
      done && rsp.status == ST_OK |-> rsp.slot != '0)
    else $error("ok result names the sentinel");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
      done && rsp.status == ST_FULL |-> rsp.live_count == COUNT_W'(NUM_SLOTS))
    else $error("full reported below capacity");

endmodule

bind indexed_doubly_linked_list_core idll_checker u_idll_checker (
  .clk   (clk),
  .rst   (rst),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire

@@ test/indexed_doubly_linked_list_core_tb.sv @@
// Self-checking testbench for indexed_doubly_linked_list_core: random insert/delete traffic.
module indexed_doubly_linked_list_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idll_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct packed {
    logic [NUM_SLOTS:0][SLOT_W-1:0] nxt;
    logic [NUM_SLOTS:0][SLOT_W-1:0] prv;
    logic [NUM_SLOTS:0]             live;
    slot_t                          free_head;
    logic [4:0]                     count;
  } list_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  req_t        pending[$];
  rsp_t        results_due[$];
  list_state_t plan;
  list_state_t model;
  logic        beat_taken = 1'b0;
  int          sent = 0;
  int          quiet = 0;
  int          errors = 0;
  int          insert_beats = 0;
  int          delete_beats = 0;
  int          status_tally[4] = '{0, 0, 0, 0};

  indexed_doubly_linked_list_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic list_state_t list_reset();
    list_state_t s;
    s = '0;
    for (int i = 1; i <= NUM_SLOTS; i++) begin
      s.nxt[i] = (i < NUM_SLOTS) ? slot_t'(i + 1) : '0;
    end
    s.free_head = slot_t'(1);
    return s;
  endfunction

  function automatic list_state_t apply_request(input list_state_t s, input req_t r,
                                                output rsp_t res);
    slot_t a;
    slot_t fresh;
    slot_t p;
    slot_t n;
    a = r.anchor;
    res.status = ST_OK;
    res.slot = '0;
    if (op_t'(r.func) == OP_INSERT) begin
      if (a != 0 && !s.live[a]) begin
        res.status = ST_NO_ANCHOR;
      end else if (s.count >= NUM_SLOTS || s.free_head == 0) begin
        res.status = ST_FULL;
      end else begin
        fresh = s.free_head;
        s.free_head = s.nxt[fresh];
        n = s.nxt[a];
        s.nxt[fresh] = n;
        s.nxt[a] = fresh;
        s.prv[fresh] = a;
        s.prv[n] = fresh;
        s.live[fresh] = 1'b1;
        s.count = s.count + 5'd1;
        res.slot = fresh;
      end
    end else begin
      if (s.count == 0) begin
        res.status = ST_EMPTY;
      end else if (a == 0 || !s.live[a]) begin
        res.status = ST_NO_ANCHOR;
      end else begin
        p = s.prv[a];
        n = s.nxt[a];
        s.nxt[p] = n;
        s.prv[n] = p;
        s.live[a] = 1'b0;
        s.prv[a] = '0;
        s.nxt[a] = s.free_head;
        s.free_head = a;
        s.count = s.count - 5'd1;
        res.slot = a;
      end
    end
    res.live_count = s.count[COUNT_W-1:0];
    return s;
  endfunction

  function automatic slot_t pick_live(input list_state_t s, input bit with_sentinel);
    int cand[$];
    if (with_sentinel) cand.push_back(0);
    for (int i = 1; i <= NUM_SLOTS; i++) begin
      if (s.live[i]) cand.push_back(i);
    end
    if (cand.size() == 0) return '0;
    return slot_t'(cand[$urandom_range(0, cand.size() - 1)]);
  endfunction

  function automatic value_t random_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_item(input op_t op, input slot_t a, input value_t v);
    req_t r;
    rsp_t unused;
    r.func = op;
    r.anchor = a;
    r.value = v;
    plan = apply_request(plan, r, unused);
    pending.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input logic [3:0] got,
                                 input logic [3:0] want);
    errors++;
    if (errors <= 40) begin
      $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
    end
  endtask

  // stimulus: directed corners, then random phases biased toward insert or delete
  initial begin
    int insert_bias;
    plan = list_reset();
    model = list_reset();
    queue_item(OP_DELETE, slot_t'(3), random_value());
    queue_item(OP_DELETE, slot_t'(0), '1);
    queue_item(OP_INSERT, slot_t'(7), '0);
    queue_item(OP_INSERT, slot_t'(0), '1);
    queue_item(OP_INSERT, slot_t'(1), '0);
    queue_item(OP_DELETE, slot_t'(0), random_value());
    queue_item(OP_DELETE, slot_t'(9), random_value());
    queue_item(OP_INSERT, slot_t'(15), random_value());
    for (int i = 0; i < 13; i++) begin
      queue_item(OP_INSERT, pick_live(plan, 1'b1), random_value());
    end
    queue_item(OP_INSERT, slot_t'(0), random_value());
    queue_item(OP_INSERT, pick_live(plan, 1'b0), random_value());
    queue_item(OP_DELETE, plan.nxt[0], random_value());
    queue_item(OP_DELETE, plan.prv[0], random_value());
    queue_item(OP_DELETE, pick_live(plan, 1'b0), random_value());
    queue_item(OP_INSERT, slot_t'(0), '1);

    insert_bias = 75;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 120 == 0) insert_bias = ((k / 120) % 2 == 0) ? 75 : 25;
      if ($urandom_range(0, 99) < insert_bias) begin
        queue_item(OP_INSERT, ($urandom_range(0, 99) < 85) ? pick_live(plan, 1'b1)
                                                          : slot_t'($urandom_range(0, 15)),
                   random_value());
      end else begin
        queue_item(OP_DELETE, ($urandom_range(0, 99) < 85) ? pick_live(plan, 1'b0)
                                                          : slot_t'($urandom_range(0, 15)),
                   random_value());
      end
    end

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    while (pending.size() != 0 || start) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("Covered %0d inserts and %0d deletes; ok %0d, bad anchor %0d, full %0d, empty %0d",
             insert_beats, delete_beats, status_tally[ST_OK], status_tally[ST_NO_ANCHOR],
             status_tally[ST_FULL], status_tally[ST_EMPTY]);
    if (errors == 0) begin
      $display("indexed_doubly_linked_list_core verification clean");
    end else begin
      $display("indexed_doubly_linked_list_core verification failed");
    end
    $finish;
  end

  // driver: hold a beat until taken, idle at random outside a quiet stretch
  always @(negedge clk) begin
    bit skip;
    if (!rst && (!start || beat_taken)) begin
      skip = (sent < 700 || sent >= 1100) && ($urandom_range(0, 99) < 32);
      if (pending.size() != 0 && !skip) begin
        start <= 1'b1;
        req <= pending.pop_front();
        sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results in order, predict on each accepted beat
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= start && !busy;
      if (done) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result", rsp.slot, '0);
        end else begin
          want = results_due.pop_front();
          if (rsp.status !== want.status) begin
            report_mismatch("status", 4'(rsp.status), 4'(want.status));
          end
          if (rsp.slot !== want.slot) report_mismatch("slot", rsp.slot, want.slot);
          if (rsp.live_count !== want.live_count) begin
            report_mismatch("live_count", rsp.live_count, want.live_count);
          end
        end
      end
      if (start && !busy) begin
        model = apply_request(model, req, want);
        results_due.push_back(want);
        status_tally[want.status]++;
        if (op_t'(req.func) == OP_INSERT) insert_beats++;
        else delete_beats++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("indexed_doubly_linked_list_core verification failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

endmodule
